// ----- rtl/interval_union_coverage_core_defines.svh -----
// assertion macros for the interval union coverage core
`ifndef INTERVAL_UNION_COVERAGE_CORE_DEFINES_SVH
`define INTERVAL_UNION_COVERAGE_CORE_DEFINES_SVH

// checked only outside reset
`define IUC_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("iuc check failed");

// checked on every edge, reset included
`define IUC_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("iuc check failed");

`endif

// ----- rtl/iuc_pkg.sv -----
// shared types and constants of the interval union coverage core
`timescale 1ns / 1ps
package iuc_pkg;
  localparam int MAX_SPANS  = 256;
  localparam int VALUE_BITS = 50;
  localparam int TOTAL_BITS = VALUE_BITS + 1;
  localparam int IDX_BITS   = $clog2(MAX_SPANS);
  localparam int CNT_BITS   = $clog2(MAX_SPANS + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVERTED = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_INVERTED,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    logic                  kind;
    logic [VALUE_BITS-1:0] range_low;
    logic [VALUE_BITS-1:0] range_high;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] covered_total;
    logic [CNT_BITS-1:0]   stored_ranges;
    logic [1:0]            status;
  } out_item_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
  } q_item_t;
endpackage

// ----- rtl/iuc_front.sv -----
// front end: takes items, classifies them and hands them to the queue
`timescale 1ns / 1ps
module iuc_front
  import iuc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_item,
  output logic     busy,
  output logic     push,
  output q_item_t  push_item,
  input  logic     q_full
);
  logic    vld_r;
  q_item_t item_r;
  q_item_t item_nxt;
  logic    take;

  assign busy = vld_r & q_full;
  assign take = start & ~busy;
  assign push = vld_r & ~q_full;
  assign push_item = item_r;

  always_comb begin
    item_nxt.lo = in_item.range_low;
    item_nxt.hi = in_item.range_high;
    if (in_item.kind == KIND_CLEAR) begin
      item_nxt.cmd = CMD_CLEAR;
    end else if (in_item.range_low > in_item.range_high) begin
      item_nxt.cmd = CMD_INVERTED;
    end else begin
      item_nxt.cmd = CMD_INSERT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (push) begin
      vld_r <= 1'b0;
    end
    if (take) begin
      item_r <= item_nxt;
    end
  end
endmodule

// ----- rtl/iuc_queue.sv -----
// two-entry queue between the front end and the sweep engine
`timescale 1ns / 1ps
module iuc_queue
  import iuc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  input  logic    pop,
  output q_item_t pop_item,
  output logic    empty,
  output logic    full
);
  q_item_t    mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end
endmodule

// ----- rtl/iuc_back.sv -----
// sweep engine: span table, merge pass over every entry, result register
`timescale 1ns / 1ps
module iuc_back
  import iuc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  q_item_t   q_item,
  output logic      pop,
  output logic      out_strobe,
  output out_item_t out_item
);
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH,
    ST_CLEAR,
    ST_INVERTED
  } state_t;

  state_t state_r;

  logic [VALUE_BITS-1:0] span_start [MAX_SPANS];
  logic [VALUE_BITS-1:0] span_end   [MAX_SPANS];
  logic [MAX_SPANS-1:0]  valid_r;
  logic [CNT_BITS-1:0]   count_r;
  logic [TOTAL_BITS-1:0] total_r;
  logic                  inverted_r;

  logic [VALUE_BITS-1:0] lo_r;
  logic [VALUE_BITS-1:0] hi_r;
  logic                  hit_r;
  logic                  found_r;
  logic [IDX_BITS-1:0]   slot_r;
  logic [IDX_BITS-1:0]   idx_r;

  // read pipeline
  logic                  rd_vld_r;
  logic                  rd_valid_r;
  logic [IDX_BITS-1:0]   rd_idx_r;
  logic [VALUE_BITS-1:0] rd_start_r;
  logic [VALUE_BITS-1:0] rd_end_r;

  logic                  overlap;
  logic                  freeable;
  logic                  drop;
  logic [TOTAL_BITS-1:0] add_size;
  logic [TOTAL_BITS-1:0] total_fin;
  logic                  rd_en;

  logic      out_strobe_r;
  out_item_t out_item_r;

  assign pop        = (state_r == ST_IDLE) & ~q_empty;
  assign rd_en      = (state_r == ST_SWEEP);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  assign overlap  = rd_vld_r & rd_valid_r & ~((hi_r < rd_start_r) | (rd_end_r < lo_r));
  assign freeable = rd_vld_r & (~rd_valid_r | overlap);
  assign drop     = ~hit_r & (count_r == CNT_BITS'(MAX_SPANS));
  assign add_size = {1'b0, hi_r} - {1'b0, lo_r} + TOTAL_BITS'(1);
  assign total_fin = drop ? total_r : total_r + add_size;

  // span memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_start_r <= span_start[idx_r];
      rd_end_r   <= span_end[idx_r];
    end
    if (state_r == ST_FINISH && !drop) begin
      span_start[slot_r] <= lo_r;
      span_end[slot_r]   <= hi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      count_r      <= '0;
      total_r      <= '0;
      inverted_r   <= 1'b0;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      rd_vld_r     <= rd_en;
      rd_idx_r     <= idx_r;
      rd_valid_r   <= valid_r[idx_r];

      // merge step on the entry read last cycle
      if (overlap) begin
        hit_r             <= 1'b1;
        lo_r              <= (rd_start_r < lo_r) ? rd_start_r : lo_r;
        hi_r              <= (rd_end_r > hi_r) ? rd_end_r : hi_r;
        total_r           <= total_r + {1'b0, rd_start_r} - {1'b0, rd_end_r}
                             - TOTAL_BITS'(1);
        valid_r[rd_idx_r] <= 1'b0;
        count_r           <= count_r - CNT_BITS'(1);
      end
      if (freeable && !found_r) begin
        found_r <= 1'b1;
        slot_r  <= rd_idx_r;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            lo_r    <= q_item.lo;
            hi_r    <= q_item.hi;
            hit_r   <= 1'b0;
            found_r <= 1'b0;
            idx_r   <= '0;
            unique case (q_item.cmd)
              CMD_CLEAR:    state_r <= ST_CLEAR;
              CMD_INVERTED: state_r <= ST_INVERTED;
              default:      state_r <= ST_SWEEP;
            endcase
          end
        end
        ST_SWEEP: begin
          idx_r <= idx_r + IDX_BITS'(1);
          if (idx_r == IDX_BITS'(MAX_SPANS - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!drop) begin
            valid_r[slot_r] <= 1'b1;
            count_r         <= count_r + CNT_BITS'(1);
          end
          total_r                  <= total_fin;
          out_strobe_r             <= 1'b1;
          out_item_r.covered_total <= inverted_r ? '0 : total_fin;
          out_item_r.stored_ranges <= drop ? count_r : count_r + CNT_BITS'(1);
          out_item_r.status        <= drop ? STATUS_FULL :
                                      (inverted_r ? STATUS_INVERTED : STATUS_OK);
          state_r                  <= ST_IDLE;
        end
        ST_CLEAR: begin
          valid_r                  <= '0;
          count_r                  <= '0;
          total_r                  <= '0;
          inverted_r               <= 1'b0;
          out_strobe_r             <= 1'b1;
          out_item_r.covered_total <= '0;
          out_item_r.stored_ranges <= '0;
          out_item_r.status        <= STATUS_OK;
          state_r                  <= ST_IDLE;
        end
        ST_INVERTED: begin
          inverted_r               <= 1'b1;
          out_strobe_r             <= 1'b1;
          out_item_r.covered_total <= '0;
          out_item_r.stored_ranges <= count_r;
          out_item_r.status        <= STATUS_INVERTED;
          state_r                  <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

// ----- rtl/interval_union_coverage_core.sv -----
// top level of the interval union coverage core
`timescale 1ns / 1ps
// Keeps a table of up to MAX_SPANS disjoint inclusive ranges forming the union
// of all inserted ranges, and answers each item with the covered count, the
// number of stored ranges and a status.
// Input: an item is taken on a rising edge with start high and busy low.
// kind 0 inserts [range_low, range_high], kind 1 clears table and error flag.
// Output: one result per item, shown for one cycle with out_strobe high; the
// receiver cannot stall, so nothing waits on the output side.
// The strobe of an insert rises after the merge pass, which reads one span
// memory entry per cycle; clear and inverted ranges raise it without that
// pass. One item is worked on at a time, so the engine takes no new item
// until the last one's result is registered. A two-entry queue and an input
// register let up to three items be taken ahead before busy rises.
// Reset (rst_n low, synchronous) empties the table, zeroes the total, clears
// the error flag and drops items still queued; no clearing pass is needed.
module interval_union_coverage_core
  import iuc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_strobe,
  output out_item_t out_item
);
  logic    push;
  q_item_t push_item;
  logic    q_full;
  logic    q_empty;
  logic    pop;
  q_item_t pop_item;

  iuc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  iuc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  iuc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (pop_item),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );
endmodule

// ----- rtl/iuc_checker.sv -----
// port checker for the interval union coverage core, with its bind
`timescale 1ns / 1ps
`include "interval_union_coverage_core_defines.svh"
module iuc_checker
  import iuc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_item
);
  // results are never strobed back to back
  `IUC_CHECK(a_strobe_gap, out_strobe |=> !out_strobe)
  `IUC_CHECK(a_status_code, out_strobe |-> (out_item.status <= STATUS_FULL))
  `IUC_CHECK(a_error_hides_total,
             (out_strobe && out_item.status == STATUS_INVERTED) |->
             (out_item.covered_total == '0))
  `IUC_CHECK(a_count_bound,
             out_strobe |-> (out_item.stored_ranges <= CNT_BITS'(MAX_SPANS)))
  `IUC_CHECK_ALWAYS(a_reset_quiet, !rst_n |=> (!out_strobe && !busy))
endmodule

bind interval_union_coverage_core iuc_checker u_iuc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
